// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, muted while reset is low
`define CHECK_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a condition in the following cycle
`define CHECK_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/saef_pkg.sv -----
`default_nettype none

package saef_pkg;

    localparam int DEF_MAX_WINDOW = 64;
    localparam int DEF_MAX_LINE   = 4096;

    localparam int PIX_W      = 8;
    localparam int WL_W       = 7;
    localparam int THR_W      = 8;
    localparam int EDGE_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = CFG_IDX_W'(1);

    localparam logic [WL_W-1:0]  WL_RESET  = WL_W'(8);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

    // pixel beat held between the address stage and the compare stage
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [PIX_W-1:0] pixel;
        logic             fwd;
        logic [PIX_W-1:0] fwd_data;
    } saef_beat_t;

endpackage

`default_nettype wire

// ----- hdl/scanline_adaptive_edge_finder.sv -----
`default_nettype none

// Adaptive edge finder for one scanline at a time: takes one pixel per clock
// whenever the result side is not stalled, and presents the start position of a
// closed edge interval starting past the window length once the closing pixel
// is registered into the compare stage and its result into the output register,
// later only while an earlier result is still stalled. The window of past pixels
// lives in a single MAX_WINDOW x 8 RAM with a registered read; each pixel's
// window entry is read in the accept cycle and written back as the pixel leaves
// the compare stage (the next cycle unless a result is stalled), with a bypass
// for the case where the next pixel reads the entry being written. No clearing
// pass is needed after reset. The pixel side stalls only while a result is
// waiting and the compare stage is occupied. Configuration writes are always
// ready and belong in idle periods; writing the window length restarts the line.
module scanline_adaptive_edge_finder #(
    parameter int MAX_WINDOW = saef_pkg::DEF_MAX_WINDOW,
    parameter int MAX_LINE   = saef_pkg::DEF_MAX_LINE
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pixel_valid,
    output logic                                 pixel_stall,
    input  wire logic [saef_pkg::PIX_W-1:0]      pixel,
    input  wire logic                            last_in_line,
    output logic                                 edge_valid,
    input  wire logic                            edge_stall,
    output logic      [saef_pkg::EDGE_W-1:0]     edge_start,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [saef_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [saef_pkg::CFG_DATA_W-1:0] cfg_data
);

    import saef_pkg::*;

    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WL_MAX = (1 << WL_W) - 1;
    localparam int NCAP   = (MAX_WINDOW < WL_MAX) ? MAX_WINDOW : WL_MAX;

    logic [WL_W-1:0]  wl_reg;
    logic [WL_W-1:0]  wl_next;
    logic [THR_W-1:0] thr_reg;
    logic [THR_W-1:0] thr_next;
    logic             cfg_we;
    logic             line_clear;
    logic [WL_W-1:0]  n;

    saef_beat_t       s1;
    logic [PTR_W-1:0] s1_addr;
    logic             hold;
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [PIX_W-1:0] ram_wdata;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic [PIX_W-1:0] rd_data;

    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign line_clear = cfg_we && (cfg_index == REG_WINDOW_LENGTH);

    // zero means one, anything past the RAM depth means the whole RAM
    assign n = (wl_reg == '0)           ? WL_W'(1) :
               (wl_reg > WL_W'(NCAP))   ? WL_W'(NCAP) : wl_reg;

    always_comb
    begin
        wl_next  = wl_reg;
        thr_next = thr_reg;
        if (cfg_we)
        begin
            if (cfg_index == REG_WINDOW_LENGTH)
            begin
                wl_next = cfg_data[WL_W-1:0];
            end
            else if (cfg_index == REG_THRESHOLD)
            begin
                thr_next = cfg_data[THR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg  <= WL_RESET;
            thr_reg <= THR_RESET;
        end
        else
        begin
            wl_reg  <= wl_next;
            thr_reg <= thr_next;
        end
    end

    saef_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .last_in_line (last_in_line),
        .n            (n),
        .line_clear   (line_clear),
        .hold         (hold),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .s1           (s1),
        .s1_addr      (s1_addr)
    );

    saef_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    saef_core #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_LINE   (MAX_LINE)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1         (s1),
        .s1_addr    (s1_addr),
        .rd_data    (rd_data),
        .n          (n),
        .threshold  (thr_reg),
        .line_clear (line_clear),
        .hold       (hold),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .edge_valid (edge_valid),
        .edge_stall (edge_stall),
        .edge_start (edge_start)
    );

endmodule

`default_nettype wire

// ----- hdl/saef_ram.sv -----
`default_nettype none

module saef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the contents from before a write in the same cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/saef_front.sv -----
`default_nettype none

`include "assert_macros.svh"

module saef_front #(
    parameter int MAX_WINDOW = saef_pkg::DEF_MAX_WINDOW,
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pixel_valid,
    output logic                            pixel_stall,
    input  wire logic [saef_pkg::PIX_W-1:0] pixel,
    input  wire logic                       last_in_line,
    input  wire logic [saef_pkg::WL_W-1:0]  n,
    input  wire logic                       line_clear,
    input  wire logic                       hold,
    input  wire logic                       ram_we,
    input  wire logic [PTR_W-1:0]           ram_waddr,
    input  wire logic [saef_pkg::PIX_W-1:0] ram_wdata,
    output logic                            rd_en,
    output logic      [PTR_W-1:0]           rd_addr,
    output saef_pkg::saef_beat_t            s1,
    output logic      [PTR_W-1:0]           s1_addr
);

    import saef_pkg::*;

    localparam int IW = ((PTR_W > WL_W) ? PTR_W : WL_W) + 1;

    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [IW-1:0]    ptr_inc;
    saef_beat_t       s1_reg;
    saef_beat_t       s1_next;
    logic [PTR_W-1:0] s1_addr_reg;
    logic [PTR_W-1:0] s1_addr_next;
    logic             accept;

    assign pixel_stall = s1_reg.valid && hold;
    assign accept      = pixel_valid && !pixel_stall;
    assign ptr_inc     = IW'(ptr_reg) + IW'(1);

    assign rd_en   = accept;
    assign rd_addr = ptr_reg;
    assign s1      = s1_reg;
    assign s1_addr = s1_addr_reg;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (line_clear)
        begin
            ptr_next = '0;
        end
        else if (accept)
        begin
            if (last_in_line || (ptr_inc >= IW'(n)))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_inc[PTR_W-1:0];
            end
        end
    end

    always_comb
    begin
        s1_next      = s1_reg;
        s1_addr_next = s1_addr_reg;
        if (accept)
        begin
            s1_next.valid    = 1'b1;
            s1_next.last     = last_in_line;
            s1_next.pixel    = pixel;
            // the entry being written back this cycle is the one read now
            s1_next.fwd      = ram_we && (ram_waddr == ptr_reg);
            s1_next.fwd_data = ram_wdata;
            s1_addr_next     = ptr_reg;
        end
        else if (!hold)
        begin
            s1_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            s1_reg  <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            s1_reg  <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= s1_addr_next;
    end

    `CHECK_AT(a_ptr_in_window, clk, rst_n, IW'(ptr_reg) < IW'(n),
        "window pointer outside the active window")
    `CHECK_NEXT(a_accept_fills_stage, clk, rst_n, accept, s1_reg.valid,
        "accepted pixel did not reach the compare stage")

endmodule

`default_nettype wire

// ----- hdl/saef_core.sv -----
`default_nettype none

`include "assert_macros.svh"

module saef_core #(
    parameter int MAX_WINDOW = saef_pkg::DEF_MAX_WINDOW,
    parameter int MAX_LINE   = saef_pkg::DEF_MAX_LINE,
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire saef_pkg::saef_beat_t        s1,
    input  wire logic [PTR_W-1:0]            s1_addr,
    input  wire logic [saef_pkg::PIX_W-1:0]  rd_data,
    input  wire logic [saef_pkg::WL_W-1:0]   n,
    input  wire logic [saef_pkg::THR_W-1:0]  threshold,
    input  wire logic                        line_clear,
    output logic                             hold,
    output logic                             ram_we,
    output logic      [PTR_W-1:0]            ram_waddr,
    output logic      [saef_pkg::PIX_W-1:0]  ram_wdata,
    output logic                             edge_valid,
    input  wire logic                        edge_stall,
    output logic      [saef_pkg::EDGE_W-1:0] edge_start
);

    import saef_pkg::*;

    localparam int POS_W  = $clog2(MAX_LINE);
    localparam int SUM_W  = $clog2(MAX_WINDOW * ((1 << PIX_W) - 1) + 1);
    localparam int PROD_W = PIX_W + 1 + WL_W;
    localparam int CW     = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
    localparam int PW     = ((POS_W > WL_W) ? POS_W : WL_W) + 1;
    localparam int XW     = (POS_W > EDGE_W) ? POS_W : EDGE_W;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              inside_reg;
    logic              inside_next;
    logic [POS_W-1:0]  start_reg;
    logic [POS_W-1:0]  start_next;
    logic              edge_valid_reg;
    logic              edge_valid_next;
    logic [EDGE_W-1:0] edge_start_reg;
    logic [EDGE_W-1:0] edge_start_next;

    logic              proc;
    logic              fill;
    logic              below;
    logic              above;
    logic              exc;
    logic              close;
    logic              emit;
    logic [PIX_W-1:0]  old_pix;
    logic [PIX_W:0]    lo_sum;
    logic [PIX_W-1:0]  hi_diff;
    logic [PROD_W-1:0] lo_prod;
    logic [PROD_W-1:0] hi_prod;
    logic [XW-1:0]     start_ext;
    logic [CW-1:0]     sum_cap;

    assign hold = edge_valid_reg && edge_stall;
    assign proc = s1.valid && !hold;

    assign old_pix = s1.fwd ? s1.fwd_data : rd_data;

    // mean test scaled by the window length, no division
    assign lo_sum  = {1'b0, s1.pixel} + {1'b0, threshold};
    assign hi_diff = s1.pixel - threshold;
    assign lo_prod = PROD_W'(lo_sum) * PROD_W'(n);
    assign hi_prod = PROD_W'(hi_diff) * PROD_W'(n);

    assign fill  = PW'(pos_reg) < PW'(n);
    assign below = CW'(lo_prod) < CW'(sum_reg);
    assign above = (s1.pixel >= threshold) && (CW'(hi_prod) > CW'(sum_reg));
    assign exc   = !fill && (below || above);
    assign close = !fill && !(below || above) && inside_reg;
    assign emit  = close && (PW'(start_reg) > PW'(n));

    assign start_ext = XW'(start_reg);
    assign sum_cap   = CW'(n) * CW'({PIX_W{1'b1}});

    assign ram_we    = proc;
    assign ram_waddr = s1_addr;
    assign ram_wdata = s1.pixel;

    assign edge_valid = edge_valid_reg;
    assign edge_start = edge_start_reg;

    always_comb
    begin
        sum_next    = sum_reg;
        pos_next    = pos_reg;
        inside_next = inside_reg;
        start_next  = start_reg;
        if (line_clear)
        begin
            sum_next    = '0;
            pos_next    = '0;
            inside_next = 1'b0;
            start_next  = '0;
        end
        else if (proc)
        begin
            if (s1.last)
            begin
                // end of line drops any open interval
                sum_next    = '0;
                pos_next    = '0;
                inside_next = 1'b0;
                start_next  = '0;
            end
            else
            begin
                if (fill)
                begin
                    sum_next = sum_reg + SUM_W'(s1.pixel);
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(s1.pixel) - SUM_W'(old_pix);
                end
                if (pos_reg != POS_W'(MAX_LINE - 1))
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                if (exc && !inside_reg)
                begin
                    inside_next = 1'b1;
                    start_next  = pos_reg;
                end
                else if (close)
                begin
                    inside_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        edge_valid_next = edge_valid_reg;
        edge_start_next = edge_start_reg;
        if (proc && emit)
        begin
            edge_valid_next = 1'b1;
            edge_start_next = start_ext[EDGE_W-1:0];
        end
        else if (!edge_stall)
        begin
            edge_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            pos_reg        <= '0;
            inside_reg     <= 1'b0;
            start_reg      <= '0;
            edge_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            pos_reg        <= pos_next;
            inside_reg     <= inside_next;
            start_reg      <= start_next;
            edge_valid_reg <= edge_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_start_reg <= edge_start_next;
    end

    `CHECK_AT(a_sum_bounded, clk, rst_n, CW'(sum_reg) <= sum_cap,
        "running sum exceeds a full window of white pixels")
    `CHECK_AT(a_result_from_compare, clk, rst_n, $rose(edge_valid_reg) |-> $past(proc),
        "result beat appeared without a processed pixel")

endmodule

`default_nettype wire
